[sv/dge_pkg.sv]
`timescale 1ns / 1ps

package dge_pkg;

    // one byte of the response with its framing and counts
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic        last_byte;
        logic [15:0] ns_count;
        logic [15:0] ar_count;
    } dge_in_t;

    // one extraction result
    typedef struct packed {
        logic [31:0] ipv4_address;
        logic        found;
    } dge_out_t;

    // result of one parser step, with its valid flag
    typedef struct packed {
        logic     valid;
        dge_out_t data;
    } dge_res_t;

endpackage

[sv/dns_glue_address_extractor.sv]
`timescale 1ns / 1ps

// Extracts the first IPv4 glue address (type A, class IN, rdlength 4) from the
// additional section of a DNS response streamed one byte per transaction.
// Parsing starts at the first 0xC0 byte, steps over ns_count authority records
// and scans ar_count additional records; the data of non-matching records is
// skipped. Each message yields at most one result: the address with found set,
// or a zero address with found clear once the byte marked last_byte is taken;
// a message cut short by a new first byte gives none.
// One byte is taken every cycle while the input does not stall: a byte waits
// in the input register, is parsed in a single step, and its result lands in
// the output register. The result register accepts a new result in the same
// cycle that the old one is taken; while a result waits there under stall,
// the held byte waits too and the input stalls.
module dns_glue_address_extractor (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  dge_pkg::dge_in_t  item,
    output logic              result_valid,
    input  logic              result_stall,
    output dge_pkg::dge_out_t result
);
    import dge_pkg::*;

    logic     held_valid;
    dge_in_t  held_item;
    logic     advance;
    dge_res_t res;

    // input register
    dge_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    // record parser state
    dge_parse_core u_parse_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .cur   (held_item),
        .res   (res)
    );

    // result register
    dge_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .held_valid   (held_valid),
        .res          (res),
        .advance      (advance),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

[sv/dge_in_stage.sv]
`timescale 1ns / 1ps

module dge_in_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  dge_pkg::dge_in_t item,
    input  logic             advance,
    output logic             held_valid,
    output dge_pkg::dge_in_t held_item
);
    import dge_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    dge_in_t item_reg;

    // hold the byte while the parser cannot take it
    assign item_stall = valid_reg && !advance;
    assign valid_next = item_stall ? valid_reg : item_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture on every accepted transaction
    always_ff @(posedge clk)
    begin
        if (!item_stall && item_valid)
        begin
            item_reg <= item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

[sv/dge_parse_core.sv]
`timescale 1ns / 1ps

module dge_parse_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  dge_pkg::dge_in_t  cur,
    output dge_pkg::dge_res_t res
);
    import dge_pkg::*;

    localparam logic [2:0] PH_SEEK      = 3'd0;
    localparam logic [2:0] PH_AUTH_HDR  = 3'd1;
    localparam logic [2:0] PH_AUTH_DATA = 3'd2;
    localparam logic [2:0] PH_ADD_HDR   = 3'd3;
    localparam logic [2:0] PH_ADD_SKIP  = 3'd4;
    localparam logic [2:0] PH_ADD_ADDR  = 3'd5;
    localparam logic [2:0] PH_TAIL      = 3'd6;
    localparam logic [2:0] PH_DONE      = 3'd7;

    localparam logic [7:0] MARK_BYTE    = 8'hC0;
    localparam logic [3:0] HEADER_BYTES = 4'd12;

    localparam logic [3:0] OFF_TYPE_HI  = 4'd2;
    localparam logic [3:0] OFF_TYPE_LO  = 4'd3;
    localparam logic [3:0] OFF_CLASS_HI = 4'd4;
    localparam logic [3:0] OFF_CLASS_LO = 4'd5;
    localparam logic [3:0] OFF_LEN_HI   = 4'd10;
    localparam logic [3:0] OFF_LEN_LO   = 4'd11;

    localparam logic [15:0] TYPE_A     = 16'd1;
    localparam logic [15:0] CLASS_IN   = 16'd1;
    localparam logic [15:0] IPV4_RDLEN = 16'd4;

    logic [2:0]  phase_reg,    phase_next;
    logic [3:0]  offset_reg,   offset_next;
    logic [15:0] len_reg,      len_next;
    logic [15:0] remain_reg,   remain_next;
    logic [15:0] auth_reg,     auth_next;
    logic [15:0] add_reg,      add_next;
    logic [15:0] rtype_reg,    rtype_next;
    logic [15:0] rclass_reg,   rclass_next;
    logic [31:0] acc_reg,      acc_next;
    logic        reported_reg, reported_next;

    // one byte of parsing, in the order the fields are laid out
    always_comb
    begin
        logic [3:0] off_inc;
        logic       hdr_done;
        logic       hit;

        phase_next    = phase_reg;
        offset_next   = offset_reg;
        len_next      = len_reg;
        remain_next   = remain_reg;
        auth_next     = auth_reg;
        add_next      = add_reg;
        rtype_next    = rtype_reg;
        rclass_next   = rclass_reg;
        acc_next      = acc_reg;
        reported_next = reported_reg;
        res           = '0;
        off_inc       = '0;
        hdr_done      = 1'b0;
        hit           = 1'b0;

        // restart on the first byte of a message
        if (cur.first_byte)
        begin
            phase_next    = PH_SEEK;
            offset_next   = '0;
            len_next      = '0;
            remain_next   = '0;
            auth_next     = cur.ns_count;
            add_next      = cur.ar_count;
            rtype_next    = '0;
            rclass_next   = '0;
            acc_next      = '0;
            reported_next = 1'b0;
        end

        // first compressed name pointer starts the records
        if (phase_next == PH_SEEK && cur.data_byte == MARK_BYTE)
        begin
            offset_next = '0;
            if (auth_next != '0)
                phase_next = PH_AUTH_HDR;
            else if (add_next != '0)
                phase_next = PH_ADD_HDR;
            else
                phase_next = PH_TAIL;
        end

        // header field capture, shared by both record sections
        if (phase_next inside {PH_AUTH_HDR, PH_ADD_HDR})
        begin
            case (offset_next)
                OFF_TYPE_HI:  rtype_next  = {cur.data_byte, 8'h00};
                OFF_TYPE_LO:  rtype_next  = rtype_next | {8'h00, cur.data_byte};
                OFF_CLASS_HI: rclass_next = {cur.data_byte, 8'h00};
                OFF_CLASS_LO: rclass_next = rclass_next | {8'h00, cur.data_byte};
                OFF_LEN_HI:   len_next    = {cur.data_byte, 8'h00};
                OFF_LEN_LO:   len_next    = len_next | {8'h00, cur.data_byte};
                default:      ;
            endcase
            off_inc = offset_next + 4'd1;
            if (off_inc >= HEADER_BYTES)
            begin
                hdr_done    = 1'b1;
                offset_next = '0;
            end
            else
            begin
                offset_next = off_inc;
            end
        end

        hit = (rtype_next == TYPE_A) && (rclass_next == CLASS_IN) && (len_next == IPV4_RDLEN);

        case (phase_next)
            PH_AUTH_HDR:
            begin
                if (hdr_done)
                begin
                    if (len_next != '0)
                    begin
                        remain_next = len_next;
                        phase_next  = PH_AUTH_DATA;
                    end
                    else
                    begin
                        if (auth_next != '0)
                            auth_next = auth_next - 16'd1;
                        offset_next = '0;
                        if (auth_next != '0)
                            phase_next = PH_AUTH_HDR;
                        else if (add_next != '0)
                            phase_next = PH_ADD_HDR;
                        else
                            phase_next = PH_TAIL;
                    end
                end
            end
            PH_AUTH_DATA:
            begin
                remain_next = remain_next - 16'd1;
                if (remain_next == '0)
                begin
                    if (auth_next != '0)
                        auth_next = auth_next - 16'd1;
                    offset_next = '0;
                    if (auth_next != '0)
                        phase_next = PH_AUTH_HDR;
                    else if (add_next != '0)
                        phase_next = PH_ADD_HDR;
                    else
                        phase_next = PH_TAIL;
                end
            end
            PH_ADD_HDR:
            begin
                if (hdr_done)
                begin
                    if (hit)
                    begin
                        remain_next = IPV4_RDLEN;
                        acc_next    = '0;
                        phase_next  = PH_ADD_ADDR;
                    end
                    else if (len_next != '0)
                    begin
                        remain_next = len_next;
                        phase_next  = PH_ADD_SKIP;
                    end
                    else
                    begin
                        if (add_next != '0)
                            add_next = add_next - 16'd1;
                        offset_next = '0;
                        phase_next  = (add_next != '0) ? PH_ADD_HDR : PH_TAIL;
                    end
                end
            end
            PH_ADD_SKIP:
            begin
                remain_next = remain_next - 16'd1;
                if (remain_next == '0)
                begin
                    if (add_next != '0)
                        add_next = add_next - 16'd1;
                    offset_next = '0;
                    phase_next  = (add_next != '0) ? PH_ADD_HDR : PH_TAIL;
                end
            end
            PH_ADD_ADDR:
            begin
                acc_next    = {acc_next[23:0], cur.data_byte};
                remain_next = remain_next - 16'd1;
                if (remain_next == '0)
                begin
                    phase_next             = PH_DONE;
                    reported_next          = 1'b1;
                    res.valid              = 1'b1;
                    res.data.ipv4_address  = acc_next;
                    res.data.found         = 1'b1;
                end
            end
            default: ;
        endcase

        // end of message with nothing reported yet
        if (!res.valid && cur.last_byte && !reported_next)
        begin
            reported_next = 1'b1;
            phase_next    = PH_DONE;
            res.valid     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SEEK;
            offset_reg   <= '0;
            len_reg      <= '0;
            remain_reg   <= '0;
            auth_reg     <= '0;
            add_reg      <= '0;
            rtype_reg    <= '0;
            rclass_reg   <= '0;
            acc_reg      <= '0;
            reported_reg <= 1'b1;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            offset_reg   <= offset_next;
            len_reg      <= len_next;
            remain_reg   <= remain_next;
            auth_reg     <= auth_next;
            add_reg      <= add_next;
            rtype_reg    <= rtype_next;
            rclass_reg   <= rclass_next;
            acc_reg      <= acc_next;
            reported_reg <= reported_next;
        end
    end

endmodule

[sv/dge_out_stage.sv]
`timescale 1ns / 1ps

module dge_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              held_valid,
    input  dge_pkg::dge_res_t res,
    output logic              advance,
    output logic              result_valid,
    input  logic              result_stall,
    output dge_pkg::dge_out_t result
);
    import dge_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    dge_out_t data_reg;
    logic     room;

    // the register can take a new transaction when empty or being drained
    assign room    = !valid_reg || !result_stall;
    assign advance = held_valid && room;

    always_comb
    begin
        valid_next = valid_reg;
        if (room)
            valid_next = advance && res.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.valid)
        begin
            data_reg <= res.data;
        end
    end

    assign result_valid = valid_reg;
    assign result       = data_reg;

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    import dge_pkg::*;

    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          DRAIN_CYCLES = 10;
    localparam logic [7:0]  MARK_BYTE    = 8'hc0;
    localparam logic [3:0]  HDR_LEN      = 4'd12;
    localparam logic [3:0]  OFS_TYPE_HI  = 4'd2;
    localparam logic [3:0]  OFS_TYPE_LO  = 4'd3;
    localparam logic [3:0]  OFS_CLASS_HI = 4'd4;
    localparam logic [3:0]  OFS_CLASS_LO = 4'd5;
    localparam logic [3:0]  OFS_LEN_HI   = 4'd10;
    localparam logic [3:0]  OFS_LEN_LO   = 4'd11;
    localparam logic [15:0] TYPE_A       = 16'd1;
    localparam logic [15:0] TYPE_NS      = 16'd2;
    localparam logic [15:0] TYPE_AAAA    = 16'd28;
    localparam logic [15:0] CLASS_IN     = 16'd1;
    localparam logic [15:0] CLASS_CH     = 16'd3;
    localparam logic [15:0] A_RDLEN      = 16'd4;

    localparam logic [2:0] PS_SEEK    = 3'd0;
    localparam logic [2:0] PS_NS_HDR  = 3'd1;
    localparam logic [2:0] PS_NS_DATA = 3'd2;
    localparam logic [2:0] PS_AR_HDR  = 3'd3;
    localparam logic [2:0] PS_AR_SKIP = 3'd4;
    localparam logic [2:0] PS_AR_ADDR = 3'd5;
    localparam logic [2:0] PS_TAIL    = 3'd6;
    localparam logic [2:0] PS_DONE    = 3'd7;

    typedef logic [7:0] octet_q_t [$];

    logic        clk = 1'b0;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    dge_in_t     item;
    logic        result_valid;
    logic        result_stall;
    dge_out_t    result;

    // parser mirror
    logic [2:0]   pp_state;
    logic [3:0]   hdr_idx;
    logic [15:0]  rec_len;
    logic [15:0]  bytes_left;
    logic [15:0]  auth_todo;
    logic [15:0]  addl_todo;
    logic [15:0]  rec_type;
    logic [15:0]  rec_class;
    logic [31:0]  addr_shift;
    logic         msg_closed;

    dge_out_t     expected_glue [$];
    dge_out_t     head_result;
    int           error_count = 0;
    int           results_seen = 0;
    int           bytes_accepted = 0;
    int unsigned  cycle_count = 0;
    int           tx_gap_pct = 0;
    int           rx_stall_pct = 0;
    int           hold_off_cycles = 0;

    dns_glue_address_extractor uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic void flag_error(string msg);
        error_count++;
        if (error_count <= 10)
            $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    function automatic void reset_parser();
        pp_state   = PS_SEEK;
        hdr_idx    = '0;
        rec_len    = '0;
        bytes_left = '0;
        auth_todo  = '0;
        addl_todo  = '0;
        rec_type   = '0;
        rec_class  = '0;
        addr_shift = '0;
        msg_closed = 1'b1;
    endfunction

    function automatic void begin_additional();
        hdr_idx  = '0;
        pp_state = (addl_todo != 16'd0) ? PS_AR_HDR : PS_TAIL;
    endfunction

    function automatic void begin_records();
        hdr_idx = '0;
        if (auth_todo != 16'd0)
            pp_state = PS_NS_HDR;
        else
            begin_additional();
    endfunction

    function automatic void close_ns_record();
        if (auth_todo != 16'd0)
            auth_todo--;
        begin_records();
    endfunction

    function automatic void close_ar_record();
        if (addl_todo != 16'd0)
            addl_todo--;
        begin_additional();
    endfunction

    // one header octet; true once the twelfth has been taken
    function automatic bit hdr_octet_done(logic [7:0] b);
        case (hdr_idx)
            OFS_TYPE_HI:  rec_type  = {b, 8'h00};
            OFS_TYPE_LO:  rec_type  = rec_type | {8'h00, b};
            OFS_CLASS_HI: rec_class = {b, 8'h00};
            OFS_CLASS_LO: rec_class = rec_class | {8'h00, b};
            OFS_LEN_HI:   rec_len   = {b, 8'h00};
            OFS_LEN_LO:   rec_len   = rec_len | {8'h00, b};
            default: ;
        endcase
        hdr_idx = hdr_idx + 4'd1;
        if (hdr_idx >= HDR_LEN)
        begin
            hdr_idx = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // advance the parser by one accepted byte, queue any result it gives
    function automatic void parse_glue_byte(dge_in_t it);
        dge_out_t r;
        if (it.first_byte)
        begin
            reset_parser();
            auth_todo  = it.ns_count;
            addl_todo  = it.ar_count;
            msg_closed = 1'b0;
        end
        if (pp_state == PS_SEEK && it.data_byte == MARK_BYTE)
            begin_records();
        case (pp_state)
            PS_NS_HDR:
            begin
                if (hdr_octet_done(it.data_byte))
                begin
                    if (rec_len != 16'd0)
                    begin
                        bytes_left = rec_len;
                        pp_state   = PS_NS_DATA;
                    end
                    else
                        close_ns_record();
                end
            end
            PS_NS_DATA:
            begin
                bytes_left--;
                if (bytes_left == 16'd0)
                    close_ns_record();
            end
            PS_AR_HDR:
            begin
                if (hdr_octet_done(it.data_byte))
                begin
                    if (rec_type == TYPE_A && rec_class == CLASS_IN && rec_len == A_RDLEN)
                    begin
                        bytes_left = A_RDLEN;
                        addr_shift = '0;
                        pp_state   = PS_AR_ADDR;
                    end
                    else if (rec_len != 16'd0)
                    begin
                        bytes_left = rec_len;
                        pp_state   = PS_AR_SKIP;
                    end
                    else
                        close_ar_record();
                end
            end
            PS_AR_SKIP:
            begin
                bytes_left--;
                if (bytes_left == 16'd0)
                    close_ar_record();
            end
            PS_AR_ADDR:
            begin
                addr_shift = {addr_shift[23:0], it.data_byte};
                bytes_left--;
                if (bytes_left == 16'd0)
                begin
                    pp_state       = PS_DONE;
                    msg_closed     = 1'b1;
                    r.ipv4_address = addr_shift;
                    r.found        = 1'b1;
                    expected_glue  = {expected_glue, r};
                    return;
                end
            end
            default: ;
        endcase
        if (it.last_byte && !msg_closed)
        begin
            msg_closed    = 1'b1;
            pp_state      = PS_DONE;
            r             = '0;
            expected_glue = {expected_glue, r};
        end
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (expected_glue.size() == 0)
                flag_error($sformatf("unexpected result addr=%h found=%b",
                                     result.ipv4_address, result.found));
            else
            begin
                head_result = expected_glue.pop_front();
                if (result.ipv4_address !== head_result.ipv4_address)
                    flag_error($sformatf("ipv4_address expected %h got %h",
                                         head_result.ipv4_address, result.ipv4_address));
                if (result.found !== head_result.found)
                    flag_error($sformatf("found expected %b got %b",
                                         head_result.found, result.found));
            end
        end
    end

    // result side: random stall bursts and the long hold-off
    initial
    begin : receiver
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles != 0)
            begin
                result_stall <= 1'b1;
                repeat (hold_off_cycles) @(posedge clk);
                hold_off_cycles = 0;
                result_stall <= 1'b0;
            end
            else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    // one byte transaction, predicted once accepted
    task automatic send_byte(input dge_in_t it);
        if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        parse_glue_byte(it);
        bytes_accepted++;
    endtask

    task automatic send_message(input octet_q_t m, input logic [15:0] ns,
                                input logic [15:0] ar, input bit with_last);
        dge_in_t it;
        foreach (m[i])
        begin
            it.data_byte  = m[i];
            it.first_byte = (i == 0);
            it.last_byte  = with_last && (i == m.size() - 1);
            it.ns_count   = (i == 0) ? ns : 16'($urandom);
            it.ar_count   = (i == 0) ? ar : 16'($urandom);
            send_byte(it);
        end
    endtask

    // compressed name, type, class, ttl, rdlength, data
    function automatic void push_record(ref octet_q_t m, input logic [15:0] rtype,
                                        input logic [15:0] rclass, input logic [15:0] rdlen,
                                        input logic [31:0] addr);
        logic [31:0] ttl;
        ttl = $urandom;
        m = {m, MARK_BYTE, 8'($urandom), rtype[15:8], rtype[7:0], rclass[15:8], rclass[7:0],
             ttl[31:24], ttl[23:16], ttl[15:8], ttl[7:0], rdlen[15:8], rdlen[7:0]};
        for (int i = 0; i < int'(rdlen); i++)
            m = {m, (rdlen == A_RDLEN) ? addr[31 - 8 * i -: 8] : 8'($urandom)};
    endfunction

    function automatic void push_random_record(ref octet_q_t m);
        int kind;
        kind = $urandom_range(0, 39);
        if (kind < 16)
            push_record(m, TYPE_A, CLASS_IN, A_RDLEN, $urandom);
        else if (kind < 20)
            push_record(m, TYPE_A, CLASS_IN,
                        ($urandom_range(0, 1) != 0) ? 16'($urandom_range(5, 8))
                                                    : 16'($urandom_range(0, 3)), $urandom);
        else if (kind < 24)
            push_record(m, TYPE_A, 16'($urandom), A_RDLEN, $urandom);
        else if (kind < 28)
            push_record(m, 16'($urandom), CLASS_IN, A_RDLEN, $urandom);
        else if (kind < 32)
            push_record(m, TYPE_AAAA, CLASS_IN, 16'd16, $urandom);
        else if (kind < 36)
            push_record(m, 16'($urandom), 16'($urandom), 16'd0, $urandom);
        else if (kind < 39)
            push_record(m, 16'($urandom), 16'($urandom), 16'($urandom_range(0, 10)), $urandom);
        else
            push_record(m, TYPE_NS, CLASS_IN, 16'(256 + $urandom_range(0, 40)), $urandom);
    endfunction

    // mostly well-formed responses, some noise, miscounts, cuts and restarts
    function automatic void build_message(ref octet_q_t m, output logic [15:0] ns,
                                          output logic [15:0] ar, output bit with_last);
        int         style;
        int         n_ns;
        int         n_ar;
        logic [7:0] b;
        m.delete();
        style     = $urandom_range(0, 99);
        with_last = ($urandom_range(0, 11) != 0);
        if (style < 25)
        begin
            repeat ($urandom_range(1, 8)) m = {m, 8'($urandom)};
            ns = 16'($urandom);
            ar = 16'($urandom);
            return;
        end
        // message header stand-in, kept free of the record mark
        repeat ($urandom_range(0, 12))
        begin
            b = 8'($urandom);
            m = {m, (b == MARK_BYTE) ? 8'h3f : b};
        end
        n_ns = $urandom_range(0, 2);
        n_ar = $urandom_range(0, 3);
        repeat (n_ns + n_ar) push_random_record(m);
        repeat ($urandom_range(0, 4)) m = {m, 8'($urandom)};
        ns = 16'(n_ns);
        ar = 16'(n_ar);
        if (style >= 90)
        begin
            ns = 16'($urandom_range(0, 3));
            ar = 16'($urandom_range(0, 4));
        end
        else if (style >= 82 && m.size() > 1)
            m = m[0:$urandom_range(0, m.size() - 1)];
        if (m.size() == 0)
            m = {m, 8'h00};
    endfunction

    task automatic run_random_messages(input int byte_goal, input int result_goal,
                                       input bit vary_idle);
        octet_q_t    m;
        logic [15:0] ns;
        logic [15:0] ar;
        bit          with_last;
        int          byte_base;
        int          result_base;
        byte_base   = bytes_accepted;
        result_base = results_seen;
        while (bytes_accepted - byte_base < byte_goal ||
               results_seen - result_base < result_goal)
        begin
            if (vary_idle)
            begin
                case ($urandom_range(0, 2))
                    0: tx_gap_pct = 0;
                    1: tx_gap_pct = 10;
                    default: tx_gap_pct = 35;
                endcase
                case ($urandom_range(0, 2))
                    0: rx_stall_pct = 0;
                    1: rx_stall_pct = 10;
                    default: rx_stall_pct = 35;
                endcase
            end
            build_message(m, ns, ar, with_last);
            send_message(m, ns, ar, with_last);
        end
    endtask

    // stray bytes after reset never give a result
    task automatic test_before_first();
        dge_in_t it;
        it           = '0;
        it.data_byte = MARK_BYTE;
        it.ns_count  = 16'hffff;
        it.ar_count  = 16'hffff;
        send_byte(it);
        it.data_byte = 8'h01;
        send_byte(it);
        it.data_byte = 8'hff;
        it.last_byte = 1'b1;
        send_byte(it);
    endtask

    task automatic test_directed();
        octet_q_t m;
        tx_gap_pct   = 20;
        rx_stall_pct = 20;
        // one-byte message, first and last together
        m = {8'h00};
        send_message(m, 16'd0, 16'd0, 1'b1);
        // authority A record is skipped, glue address completes on the last byte
        m = {8'h12, 8'h34};
        push_record(m, TYPE_A, CLASS_IN, A_RDLEN, 32'h0a0b0c0d);
        push_record(m, TYPE_A, CLASS_IN, A_RDLEN, 32'hffffffff);
        send_message(m, 16'd1, 16'd1, 1'b1);
        // zero rdlength and non-matching records ahead of a zero address, then trailing bytes
        m.delete();
        push_record(m, TYPE_AAAA, CLASS_IN, 16'd0, '0);
        push_record(m, TYPE_A, CLASS_IN, 16'd5, '0);
        push_record(m, TYPE_A, CLASS_CH, A_RDLEN, 32'h01020304);
        push_record(m, TYPE_A, CLASS_IN, A_RDLEN, 32'h00000000);
        m = {m, MARK_BYTE, 8'hff};
        send_message(m, 16'd0, 16'd4, 1'b1);
        // zero rdlength in the authority section
        m.delete();
        push_record(m, TYPE_NS, CLASS_IN, 16'd0, '0);
        push_record(m, TYPE_A, CLASS_IN, A_RDLEN, 32'h80000001);
        send_message(m, 16'd1, 16'd1, 1'b1);
        // largest counts: the message ends inside the authority section
        m.delete();
        push_record(m, TYPE_A, CLASS_IN, A_RDLEN, 32'hdeadbeef);
        send_message(m, 16'hffff, 16'hffff, 1'b1);
        // zero counts, parser waits after the mark
        m = {8'h00, MARK_BYTE, 8'h00, 8'h01};
        send_message(m, 16'd0, 16'd0, 1'b1);
        // no record mark anywhere
        m = {8'h81, 8'h80, 8'h00, 8'h3f, 8'hff};
        send_message(m, 16'd0, 16'd1, 1'b1);
        // restart mid-address: the cut message is dropped without a result
        m.delete();
        push_record(m, TYPE_A, CLASS_IN, A_RDLEN, 32'h11223344);
        m = m[0:13];
        send_message(m, 16'd0, 16'd1, 1'b0);
        m = {8'h55};
        send_message(m, 16'd0, 16'd0, 1'b1);
    endtask

    // result side held off while short messages keep coming
    task automatic test_backpressure();
        octet_q_t m;
        tx_gap_pct      = 0;
        rx_stall_pct    = 0;
        hold_off_cycles = 300;
        repeat (48)
        begin
            m = {8'($urandom)};
            send_message(m, 16'($urandom), 16'($urandom), 1'b1);
        end
        while (hold_off_cycles != 0)
            @(posedge clk);
    endtask

    task automatic test_random();
        run_random_messages(650, 30, 1'b1);
    endtask

    // closing stretch at full rate on both sides
    task automatic test_full_rate();
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        run_random_messages(200, 0, 1'b0);
    endtask

    initial
    begin : main
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        reset_parser();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_before_first();
        test_directed();
        test_backpressure();
        test_random();
        test_full_rate();
        item_valid <= 1'b0;

        // drain outstanding results
        while (expected_glue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
